// ===== rtl/qvr_pkg.sv =====
// Shared types and constants for the quaternion vector rotator.
// Used by the channel interfaces, the row datapath and the top level.
package qvr_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int QUAT_W         = 16;
	localparam int PROD_W         = 2 * QUAT_W;
	// Diagonal entries stay within +/-2^31 and off-diagonal ones within +/-2^32.
	localparam int MAT_W          = PROD_W + 2;
	localparam int FRAC_SHIFT     = 2 * (QUAT_W - 1);
	localparam int OUT_W          = 18;
	localparam int OUT_MAX        = 131071;
	localparam int OUT_MIN        = -131072;
	localparam int CFG_IDX_W      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_X = 3'd0,
		REG_QUAT_Y = 3'd1,
		REG_QUAT_Z = 3'd2,
		REG_QUAT_W = 3'd3
	} qvr_reg_t;

	// Load enables of the stages that live in the row datapath.
	typedef struct packed {
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} qvr_adv_t;

endpackage

// ===== rtl/qvr_if.sv =====
// Valid/ready channel interfaces for the input vector and the rotated result.
// Depends on qvr_pkg for default widths.
interface qvr_vec_if #(
	parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] vec_x;
	logic signed [DATA_WIDTH-1:0] vec_y;
	logic signed [DATA_WIDTH-1:0] vec_z;
	logic                         inverse;

	modport source (output valid, output vec_x, output vec_y, output vec_z, output inverse,
		input ready);
	modport sink (input valid, input vec_x, input vec_y, input vec_z, input inverse,
		output ready);
endinterface

interface qvr_rot_if;
	logic                            valid;
	logic                            ready;
	logic signed [qvr_pkg::OUT_W-1:0] rot_x;
	logic signed [qvr_pkg::OUT_W-1:0] rot_y;
	logic signed [qvr_pkg::OUT_W-1:0] rot_z;
	logic                            clipped;

	modport source (output valid, output rot_x, output rot_y, output rot_z, output clipped,
		input ready);
	modport sink (input valid, input rot_x, input rot_y, input rot_z, input clipped,
		output ready);
endinterface

// ===== rtl/qvr_row.sv =====
// One output row of the rotator: three products, rounded sum, saturation.
// Holds pipeline stages 3 to 5; depends on qvr_pkg.
module qvr_row #(
	parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  qvr_pkg::qvr_adv_t                  adv,
	input  logic signed [qvr_pkg::MAT_W-1:0]   coef [3],
	input  logic signed [DATA_WIDTH-1:0]       vec [3],
	output logic signed [qvr_pkg::OUT_W-1:0]   rot,
	output logic                               clip
);
	import qvr_pkg::*;

	localparam int PW    = MAT_W + DATA_WIDTH;
	localparam int ACC_W = PW + 2;
	localparam int Q_W   = ACC_W - FRAC_SHIFT;
	localparam int EXT_W = (Q_W > OUT_W) ? Q_W : OUT_W;
	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC_SHIFT - 1);
	localparam logic signed [EXT_W-1:0] SAT_HI   = EXT_W'(OUT_MAX);
	localparam logic signed [EXT_W-1:0] SAT_LO   = EXT_W'(OUT_MIN);

	logic signed [PW-1:0]    prod_s3 [3];
	logic signed [ACC_W-1:0] acc;
	logic signed [Q_W-1:0]   q_s4;
	logic signed [EXT_W-1:0] q_ext;

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= PW'(coef[i]) * PW'(vec[i]);
			end
		end
	end

	// Adding half an LSB and keeping the upper bits rounds ties upward.
	assign acc = ACC_W'(prod_s3[0]) + ACC_W'(prod_s3[1]) + ACC_W'(prod_s3[2]) + HALF_LSB;

	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			q_s4 <= acc[ACC_W-1:FRAC_SHIFT];
		end
	end

	assign q_ext = EXT_W'(q_s4);

	always_ff @(posedge clk) begin
		if (adv.en_s5) begin
			if (q_ext > SAT_HI) begin
				rot  <= OUT_W'(OUT_MAX);
				clip <= 1'b1;
			end else if (q_ext < SAT_LO) begin
				rot  <= OUT_W'(OUT_MIN);
				clip <= 1'b1;
			end else begin
				rot  <= q_ext[OUT_W-1:0];
				clip <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/quaternion_vector_rotate.sv =====
// Quaternion vector rotator: out = (a^2 - b.b)v + 2(b.v)b + 2a(b x v), rounded, saturated.
// One beat is accepted per cycle while vin.ready is high, that is unless every stage is full and the output stalls.
// Stages: quaternion products, rotation matrix, row products, rounded sum, saturation.
// Every stage holds its own valid bit, so a stalled output lets upstream bubbles close.
// Reset clears all valid bits and loads the identity quaternion (w = 32767).
module quaternion_vector_rotate #(
	parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [qvr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qvr_pkg::QUAT_W-1:0]         cfg_data,
	qvr_vec_if.sink                            vin,
	qvr_rot_if.source                          rout
);
	import qvr_pkg::*;

	logic signed [QUAT_W-1:0] quat_x_q, quat_y_q, quat_z_q, quat_w_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	qvr_adv_t row_adv;

	logic signed [PROD_W-1:0] aa_s1, xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1;
	logic signed [PROD_W-1:0] ax_s1, ay_s1, az_s1;
	logic signed [DATA_WIDTH-1:0] vec_s1 [3];
	logic signed [DATA_WIDTH-1:0] vec_s2 [3];
	logic inv_s1;

	logic signed [MAT_W-1:0] mat_d [3][3];
	logic signed [MAT_W-1:0] mat_s2 [3][3];
	logic signed [MAT_W-1:0] a2, x2, y2, z2, pxy, pxz, pyz, qx, qy, qz;

	logic signed [OUT_W-1:0] rot_v [3];
	logic [2:0] clip_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_x_q <= '0;
			quat_y_q <= '0;
			quat_z_q <= '0;
			quat_w_q <= QUAT_W'(32767);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUAT_X: quat_x_q <= cfg_data;
				REG_QUAT_Y: quat_y_q <= cfg_data;
				REG_QUAT_Z: quat_z_q <= cfg_data;
				REG_QUAT_W: quat_w_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when the stage after it moves on.
	assign adv_s5 = !valid_s5 || rout.ready;
	assign adv_s4 = !valid_s4 || adv_s5;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign vin.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= vin.valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: all pairwise quaternion products.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			aa_s1     <= PROD_W'(quat_w_q) * PROD_W'(quat_w_q);
			xx_s1     <= PROD_W'(quat_x_q) * PROD_W'(quat_x_q);
			yy_s1     <= PROD_W'(quat_y_q) * PROD_W'(quat_y_q);
			zz_s1     <= PROD_W'(quat_z_q) * PROD_W'(quat_z_q);
			xy_s1     <= PROD_W'(quat_x_q) * PROD_W'(quat_y_q);
			xz_s1     <= PROD_W'(quat_x_q) * PROD_W'(quat_z_q);
			yz_s1     <= PROD_W'(quat_y_q) * PROD_W'(quat_z_q);
			ax_s1     <= PROD_W'(quat_w_q) * PROD_W'(quat_x_q);
			ay_s1     <= PROD_W'(quat_w_q) * PROD_W'(quat_y_q);
			az_s1     <= PROD_W'(quat_w_q) * PROD_W'(quat_z_q);
			vec_s1[0] <= vin.vec_x;
			vec_s1[1] <= vin.vec_y;
			vec_s1[2] <= vin.vec_z;
			inv_s1    <= vin.inverse;
		end
	end

	// Stage 2: rotation matrix. Inverting b flips only the a*b terms, which
	// amounts to swapping each off-diagonal pair.
	always_comb begin
		a2  = MAT_W'(aa_s1);
		x2  = MAT_W'(xx_s1);
		y2  = MAT_W'(yy_s1);
		z2  = MAT_W'(zz_s1);
		pxy = MAT_W'(xy_s1) + MAT_W'(xy_s1);
		pxz = MAT_W'(xz_s1) + MAT_W'(xz_s1);
		pyz = MAT_W'(yz_s1) + MAT_W'(yz_s1);
		qx  = MAT_W'(ax_s1) + MAT_W'(ax_s1);
		qy  = MAT_W'(ay_s1) + MAT_W'(ay_s1);
		qz  = MAT_W'(az_s1) + MAT_W'(az_s1);
		mat_d[0][0] = a2 + x2 - y2 - z2;
		mat_d[1][1] = a2 - x2 + y2 - z2;
		mat_d[2][2] = a2 - x2 - y2 + z2;
		mat_d[0][1] = inv_s1 ? pxy + qz : pxy - qz;
		mat_d[1][0] = inv_s1 ? pxy - qz : pxy + qz;
		mat_d[0][2] = inv_s1 ? pxz - qy : pxz + qy;
		mat_d[2][0] = inv_s1 ? pxz + qy : pxz - qy;
		mat_d[1][2] = inv_s1 ? pyz + qx : pyz - qx;
		mat_d[2][1] = inv_s1 ? pyz - qx : pyz + qx;
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			mat_s2 <= mat_d;
			vec_s2 <= vec_s1;
		end
	end

	assign row_adv = '{en_s3: adv_s3, en_s4: adv_s4, en_s5: adv_s5};

	for (genvar r = 0; r < 3; r++) begin : g_row
		qvr_row #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_row (
			.clk  (clk),
			.adv  (row_adv),
			.coef (mat_s2[r]),
			.vec  (vec_s2),
			.rot  (rot_v[r]),
			.clip (clip_v[r])
		);
	end

	assign rout.valid   = valid_s5;
	assign rout.rot_x   = rot_v[0];
	assign rout.rot_y   = rot_v[1];
	assign rout.rot_z   = rot_v[2];
	assign rout.clipped = |clip_v;

	// A clipped beat must carry at least one component on a rail.
	a_clip_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		rout.valid && rout.clipped |->
			(rout.rot_x == OUT_W'(OUT_MAX)) || (rout.rot_x == OUT_W'(OUT_MIN)) ||
			(rout.rot_y == OUT_W'(OUT_MAX)) || (rout.rot_y == OUT_W'(OUT_MIN)) ||
			(rout.rot_z == OUT_W'(OUT_MAX)) || (rout.rot_z == OUT_W'(OUT_MIN)))
		else $error("clipped beat without a saturated component");

	// The input is held off only when every stage is full and the output stalls.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!vin.ready |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && !rout.ready)
		else $error("input stalled while the pipeline has a free stage");

	// A beat that leaves stage 4 lands in stage 5 on the next edge.
	a_s4_to_s5: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && adv_s5 |=> valid_s5)
		else $error("beat lost between row sum and output stage");

endmodule
